### src/mmba_pkg.sv
// ----------------------------------------------------------------------------
// Modular matrix bank ALU package
// Types, constants and modular arithmetic helpers shared by the block.
// ----------------------------------------------------------------------------
package mmba_pkg;

  localparam int MAX_DIM      = 32;
  localparam int NUM_MATRICES = 16;
  localparam int ELEM_W       = 30;
  localparam int IDX_W        = $clog2(MAX_DIM);
  localparam int SLOT_W       = $clog2(NUM_MATRICES);
  localparam int DIM_W        = 6;
  localparam int OP_W         = 3;
  localparam int BIT_CNT_W    = $clog2(ELEM_W);
  localparam int SCR_DEPTH    = MAX_DIM * MAX_DIM;
  localparam int BANK_DEPTH   = NUM_MATRICES * SCR_DEPTH;
  localparam int SCR_AW       = $clog2(SCR_DEPTH);
  localparam int BANK_AW      = $clog2(BANK_DEPTH);

  localparam logic [ELEM_W-1:0] PRIME = ELEM_W'(1000000007);
  localparam logic [DIM_W-1:0]  MAX_DIM_V = DIM_W'(MAX_DIM);
  localparam logic [DIM_W-1:0]  DIM_RESET = DIM_W'(1);

  localparam logic [OP_W-1:0] OP_WRITE = 3'd0;
  localparam logic [OP_W-1:0] OP_READ  = 3'd1;
  localparam logic [OP_W-1:0] OP_ADD   = 3'd2;
  localparam logic [OP_W-1:0] OP_SUB   = 3'd3;
  localparam logic [OP_W-1:0] OP_MUL   = 3'd4;

  typedef struct packed {
    logic [OP_W-1:0]   operation;
    logic [SLOT_W-1:0] dest_matrix;
    logic [SLOT_W-1:0] left_matrix;
    logic [SLOT_W-1:0] right_matrix;
    logic [IDX_W-1:0]  row;
    logic [IDX_W-1:0]  col;
    logic [ELEM_W-1:0] value;
  } in_word_t;

  typedef struct packed {
    logic [ELEM_W-1:0] read_value;
    logic              index_error;
  } out_word_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_DECODE, ST_WR, ST_RD_ADDR, ST_RD_CAP,
    ST_EW_RL, ST_EW_RR, ST_EW_CAP, ST_EW_WR,
    ST_MU_START, ST_MU_RL, ST_MU_RR, ST_MU_CAP, ST_MU_MM, ST_MU_ACC, ST_MU_SW,
    ST_CP_RD, ST_CP_WR, ST_DONE
  } state_t;

  typedef enum logic [2:0] {
    RA_LEFT_RC, RA_LEFT_IJ, RA_RIGHT_IJ, RA_LEFT_IK, RA_RIGHT_KJ
  } ra_sel_t;

  typedef enum logic [0:0] {WA_DEST_RC, WA_DEST_IJ} wa_sel_t;

  typedef enum logic [1:0] {WD_VALUE, WD_EW, WD_SCRATCH} wd_sel_t;

  typedef struct packed {
    logic    latch_in;
    logic    clr_ij;
    logic    step_ij;
    logic    clr_k;
    logic    inc_k;
    logic    cap_a;
    logic    cap_b;
    logic    mm_init;
    logic    mm_step;
    logic    acc_clr;
    logic    acc_add;
    logic    cap_rd;
    logic    bank_we;
    logic    scr_we;
    logic    load_out;
    ra_sel_t ra_sel;
    wa_sel_t wa_sel;
    wd_sel_t wd_sel;
  } cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            idx_err;
    logic            n_zero;
    logic            ij_last;
    logic            k_last;
    logic            bit_last;
    logic            out_blocked;
  } status_t;

  function automatic logic [ELEM_W-1:0] mod_add(input logic [ELEM_W-1:0] a,
                                                input logic [ELEM_W-1:0] b);
    logic [ELEM_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= {1'b0, PRIME}) begin
      s = s - {1'b0, PRIME};
    end
    return s[ELEM_W-1:0];
  endfunction

  function automatic logic [ELEM_W-1:0] mod_sub(input logic [ELEM_W-1:0] a,
                                                input logic [ELEM_W-1:0] b);
    logic [ELEM_W-1:0] d;
    if (a >= b) begin
      d = a - b;
    end else begin
      d = a + (PRIME - b);
    end
    return d;
  endfunction

endpackage

### src/mmba_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module mmba_ram #(
  parameter int WIDTH = 30,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### src/mmba_dp.sv
// ----------------------------------------------------------------------------
// Modular matrix bank ALU datapath
// Bank and scratch memories, loop indices, modular multiply-accumulate unit
// and the result register.
// ----------------------------------------------------------------------------
module mmba_dp (
  input  logic              clk,
  input  logic              rst,
  input  mmba_pkg::in_word_t in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output mmba_pkg::out_word_t out_data,
  input  logic              cfg_we,
  input  logic [5:0]        cfg_data,
  input  mmba_pkg::cmd_t    cmd,
  output mmba_pkg::status_t status
);

  import mmba_pkg::*;

  in_word_t          req;
  logic [DIM_W-1:0]  dimension;
  logic [DIM_W-1:0]  n;
  logic [IDX_W-1:0]  i, j, k;
  logic [BIT_CNT_W-1:0] bit_cnt;
  logic [ELEM_W-1:0] op_a, op_b, mm_r, acc, rd_val;
  logic [ELEM_W-1:0] bank_rdata, scr_rdata, bank_wdata, ew_val, wr_val;
  logic [BANK_AW-1:0] bank_raddr, bank_waddr;
  logic [SCR_AW-1:0]  scr_addr;
  logic              j_last, i_last;

  assign n = (dimension > MAX_DIM_V) ? MAX_DIM_V : dimension;
  assign j_last = ({1'b0, j} == n - DIM_W'(1));
  assign i_last = ({1'b0, i} == n - DIM_W'(1));

  always_comb begin
    status.op          = req.operation;
    status.idx_err     = ({1'b0, req.row} >= n) || ({1'b0, req.col} >= n);
    status.n_zero      = (n == '0);
    status.ij_last     = i_last && j_last;
    status.k_last      = ({1'b0, k} == n - DIM_W'(1));
    status.bit_last    = (bit_cnt == '0);
    status.out_blocked = out_valid && out_stall;
  end

  always_comb begin
    unique case (cmd.ra_sel)
      RA_LEFT_RC:  bank_raddr = {req.left_matrix, req.row, req.col};
      RA_LEFT_IJ:  bank_raddr = {req.left_matrix, i, j};
      RA_RIGHT_IJ: bank_raddr = {req.right_matrix, i, j};
      RA_LEFT_IK:  bank_raddr = {req.left_matrix, i, k};
      RA_RIGHT_KJ: bank_raddr = {req.right_matrix, k, j};
      default:     bank_raddr = {req.left_matrix, i, j};
    endcase
  end

  assign bank_waddr = (cmd.wa_sel == WA_DEST_RC) ? {req.dest_matrix, req.row, req.col}
                                                 : {req.dest_matrix, i, j};
  assign scr_addr = {i, j};

  assign ew_val = (req.operation == OP_SUB) ? mod_sub(op_a, op_b) : mod_add(op_a, op_b);
  assign wr_val = (req.value >= PRIME) ? req.value - PRIME : req.value;

  always_comb begin
    unique case (cmd.wd_sel)
      WD_VALUE:   bank_wdata = wr_val;
      WD_EW:      bank_wdata = ew_val;
      WD_SCRATCH: bank_wdata = scr_rdata;
      default:    bank_wdata = wr_val;
    endcase
  end

  mmba_ram #(.WIDTH(ELEM_W), .DEPTH(BANK_DEPTH)) u_bank (
    .clk   (clk),
    .we    (cmd.bank_we),
    .waddr (bank_waddr),
    .wdata (bank_wdata),
    .raddr (bank_raddr),
    .rdata (bank_rdata)
  );

  mmba_ram #(.WIDTH(ELEM_W), .DEPTH(SCR_DEPTH)) u_scratch (
    .clk   (clk),
    .we    (cmd.scr_we),
    .waddr (scr_addr),
    .wdata (acc),
    .raddr (scr_addr),
    .rdata (scr_rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      req <= in_data;
    end
    if (cmd.clr_ij) begin
      i <= '0;
      j <= '0;
    end else if (cmd.step_ij) begin
      if (j_last) begin
        j <= '0;
        i <= i_last ? '0 : i + IDX_W'(1);
      end else begin
        j <= j + IDX_W'(1);
      end
    end
    if (cmd.clr_k) begin
      k <= '0;
    end else if (cmd.inc_k) begin
      k <= k + IDX_W'(1);
    end
    if (cmd.cap_a) begin
      op_a <= bank_rdata;
    end
    if (cmd.cap_b) begin
      op_b <= bank_rdata;
    end
    if (cmd.mm_init) begin
      mm_r    <= '0;
      bit_cnt <= BIT_CNT_W'(ELEM_W - 1);
    end else if (cmd.mm_step) begin
      mm_r    <= mod_add(mod_add(mm_r, mm_r), op_b[ELEM_W-1] ? op_a : '0);
      op_b    <= {op_b[ELEM_W-2:0], 1'b0};
      bit_cnt <= bit_cnt - BIT_CNT_W'(1);
    end
    if (cmd.acc_clr) begin
      acc <= '0;
    end else if (cmd.acc_add) begin
      acc <= mod_add(acc, mm_r);
    end
    if (cmd.latch_in) begin
      rd_val <= '0;
    end else if (cmd.cap_rd) begin
      rd_val <= bank_rdata;
    end
    if (cmd.load_out) begin
      out_data.read_value  <= rd_val;
      out_data.index_error <= ((req.operation == OP_WRITE) || (req.operation == OP_READ))
                              && status.idx_err;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dimension <= DIM_RESET;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        dimension <= cfg_data;
      end
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

### src/mmba_ctrl.sv
// ----------------------------------------------------------------------------
// Modular matrix bank ALU controller
// Sequences each command through the datapath, one word at a time.
// ----------------------------------------------------------------------------
module mmba_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  mmba_pkg::status_t status,
  output mmba_pkg::cmd_t    cmd
);

  import mmba_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.ra_sel = RA_LEFT_IJ;
    cmd.wa_sel = WA_DEST_IJ;
    cmd.wd_sel = WD_EW;
    in_stall   = (state != ST_IDLE);
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.latch_in = 1'b1;
          state_next   = ST_DECODE;
        end
      end
      ST_DECODE: begin
        cmd.clr_ij = 1'b1;
        priority if (status.op == OP_WRITE) begin
          state_next = status.idx_err ? ST_DONE : ST_WR;
        end else if (status.op == OP_READ) begin
          state_next = status.idx_err ? ST_DONE : ST_RD_ADDR;
        end else if (status.op == OP_ADD || status.op == OP_SUB) begin
          state_next = status.n_zero ? ST_DONE : ST_EW_RL;
        end else if (status.op == OP_MUL) begin
          state_next = status.n_zero ? ST_DONE : ST_MU_START;
        end else begin
          state_next = ST_DONE;
        end
      end
      ST_WR: begin
        cmd.bank_we = 1'b1;
        cmd.wa_sel  = WA_DEST_RC;
        cmd.wd_sel  = WD_VALUE;
        state_next  = ST_DONE;
      end
      ST_RD_ADDR: begin
        cmd.ra_sel = RA_LEFT_RC;
        state_next = ST_RD_CAP;
      end
      ST_RD_CAP: begin
        cmd.cap_rd = 1'b1;
        state_next = ST_DONE;
      end
      ST_EW_RL: begin
        cmd.ra_sel = RA_LEFT_IJ;
        state_next = ST_EW_RR;
      end
      ST_EW_RR: begin
        cmd.ra_sel = RA_RIGHT_IJ;
        cmd.cap_a  = 1'b1;
        state_next = ST_EW_CAP;
      end
      ST_EW_CAP: begin
        cmd.cap_b  = 1'b1;
        state_next = ST_EW_WR;
      end
      ST_EW_WR: begin
        cmd.bank_we = 1'b1;
        cmd.wd_sel  = WD_EW;
        cmd.step_ij = 1'b1;
        state_next  = status.ij_last ? ST_DONE : ST_EW_RL;
      end
      ST_MU_START: begin
        cmd.acc_clr = 1'b1;
        cmd.clr_k   = 1'b1;
        state_next  = ST_MU_RL;
      end
      ST_MU_RL: begin
        cmd.ra_sel = RA_LEFT_IK;
        state_next = ST_MU_RR;
      end
      ST_MU_RR: begin
        cmd.ra_sel = RA_RIGHT_KJ;
        cmd.cap_a  = 1'b1;
        state_next = ST_MU_CAP;
      end
      ST_MU_CAP: begin
        cmd.cap_b   = 1'b1;
        cmd.mm_init = 1'b1;
        state_next  = ST_MU_MM;
      end
      ST_MU_MM: begin
        cmd.mm_step = 1'b1;
        state_next  = status.bit_last ? ST_MU_ACC : ST_MU_MM;
      end
      ST_MU_ACC: begin
        cmd.acc_add = 1'b1;
        cmd.inc_k   = 1'b1;
        state_next  = status.k_last ? ST_MU_SW : ST_MU_RL;
      end
      ST_MU_SW: begin
        cmd.scr_we  = 1'b1;
        cmd.step_ij = 1'b1;
        state_next  = status.ij_last ? ST_CP_RD : ST_MU_START;
      end
      ST_CP_RD: begin
        state_next = ST_CP_WR;
      end
      ST_CP_WR: begin
        cmd.bank_we = 1'b1;
        cmd.wd_sel  = WD_SCRATCH;
        cmd.step_ij = 1'b1;
        state_next  = status.ij_last ? ST_DONE : ST_CP_RD;
      end
      ST_DONE: begin
        if (!status.out_blocked) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

### src/modular_matrix_bank_alu_unit.sv
// One word is processed at a time; the next is taken the cycle after the result
// is loaded. The modular multiply is a 30-step shift-and-add loop, one bit per cycle.
// Reset clears the controller and result valid and sets the dimension to one;
// the matrix bank holds no defined contents until written.
// ----------------------------------------------------------------------------
// Modular matrix bank ALU
// Bank of square matrices of residues modulo 1000000007 with element write,
// element read, element-wise add and subtract, and matrix multiply.
// ----------------------------------------------------------------------------
module modular_matrix_bank_alu_unit (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  mmba_pkg::in_word_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output mmba_pkg::out_word_t out_data,
  input  logic                cfg_we,
  input  logic [5:0]          cfg_data
);

  import mmba_pkg::*;

  cmd_t    cmd;
  status_t status;

  mmba_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  mmba_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .status    (status)
  );

endmodule
